// ===== design/md5_pkg.sv =====
// MD5 package: word and digest payload types, initial vector, step constants
// and the per-step shift and message index tables.
// No dependencies; imported by md5_message_digest.
package md5_pkg;

	typedef struct packed {
		logic [31:0] message_word;
		logic [2:0]  byte_count;
		logic        last_word;
	} md5_word_t;

	typedef struct packed {
		logic [31:0] digest_a;
		logic [31:0] digest_b;
		logic [31:0] digest_c;
		logic [31:0] digest_d;
	} md5_digest_t;

	localparam logic [31:0] IV_A = 32'h67452301;
	localparam logic [31:0] IV_B = 32'hefcdab89;
	localparam logic [31:0] IV_C = 32'h98badcfe;
	localparam logic [31:0] IV_D = 32'h10325476;

	localparam logic [31:0] PAD_BYTE = 32'h00000080;

	// Additive constant of each step.
	function automatic logic [31:0] step_const(input logic [5:0] r);
		logic [31:0] k;
		unique case (r)
			6'd0:  k = 32'hd76aa478;  6'd1:  k = 32'he8c7b756;
			6'd2:  k = 32'h242070db;  6'd3:  k = 32'hc1bdceee;
			6'd4:  k = 32'hf57c0faf;  6'd5:  k = 32'h4787c62a;
			6'd6:  k = 32'ha8304613;  6'd7:  k = 32'hfd469501;
			6'd8:  k = 32'h698098d8;  6'd9:  k = 32'h8b44f7af;
			6'd10: k = 32'hffff5bb1;  6'd11: k = 32'h895cd7be;
			6'd12: k = 32'h6b901122;  6'd13: k = 32'hfd987193;
			6'd14: k = 32'ha679438e;  6'd15: k = 32'h49b40821;
			6'd16: k = 32'hf61e2562;  6'd17: k = 32'hc040b340;
			6'd18: k = 32'h265e5a51;  6'd19: k = 32'he9b6c7aa;
			6'd20: k = 32'hd62f105d;  6'd21: k = 32'h02441453;
			6'd22: k = 32'hd8a1e681;  6'd23: k = 32'he7d3fbc8;
			6'd24: k = 32'h21e1cde6;  6'd25: k = 32'hc33707d6;
			6'd26: k = 32'hf4d50d87;  6'd27: k = 32'h455a14ed;
			6'd28: k = 32'ha9e3e905;  6'd29: k = 32'hfcefa3f8;
			6'd30: k = 32'h676f02d9;  6'd31: k = 32'h8d2a4c8a;
			6'd32: k = 32'hfffa3942;  6'd33: k = 32'h8771f681;
			6'd34: k = 32'h6d9d6122;  6'd35: k = 32'hfde5380c;
			6'd36: k = 32'ha4beea44;  6'd37: k = 32'h4bdecfa9;
			6'd38: k = 32'hf6bb4b60;  6'd39: k = 32'hbebfbc70;
			6'd40: k = 32'h289b7ec6;  6'd41: k = 32'heaa127fa;
			6'd42: k = 32'hd4ef3085;  6'd43: k = 32'h04881d05;
			6'd44: k = 32'hd9d4d039;  6'd45: k = 32'he6db99e5;
			6'd46: k = 32'h1fa27cf8;  6'd47: k = 32'hc4ac5665;
			6'd48: k = 32'hf4292244;  6'd49: k = 32'h432aff97;
			6'd50: k = 32'hab9423a7;  6'd51: k = 32'hfc93a039;
			6'd52: k = 32'h655b59c3;  6'd53: k = 32'h8f0ccc92;
			6'd54: k = 32'hffeff47d;  6'd55: k = 32'h85845dd1;
			6'd56: k = 32'h6fa87e4f;  6'd57: k = 32'hfe2ce6e0;
			6'd58: k = 32'ha3014314;  6'd59: k = 32'h4e0811a1;
			6'd60: k = 32'hf7537e82;  6'd61: k = 32'hbd3af235;
			6'd62: k = 32'h2ad7d2bb;  6'd63: k = 32'heb86d391;
			default: k = 32'h0;
		endcase
		return k;
	endfunction

	// Left-rotate amount of each step: four per quarter.
	function automatic logic [4:0] step_shift(input logic [5:0] r);
		logic [4:0] s;
		unique case ({r[5:4], r[1:0]})
			4'd0:  s = 5'd7;   4'd1:  s = 5'd12;  4'd2:  s = 5'd17;  4'd3:  s = 5'd22;
			4'd4:  s = 5'd5;   4'd5:  s = 5'd9;   4'd6:  s = 5'd14;  4'd7:  s = 5'd20;
			4'd8:  s = 5'd4;   4'd9:  s = 5'd11;  4'd10: s = 5'd16;  4'd11: s = 5'd23;
			4'd12: s = 5'd6;   4'd13: s = 5'd10;  4'd14: s = 5'd15;  4'd15: s = 5'd21;
			default: s = 5'd0;
		endcase
		return s;
	endfunction

	// Message word used by each step; all arithmetic is modulo 16.
	function automatic logic [3:0] step_index(input logic [5:0] r);
		logic [3:0] g;
		unique case (r[5:4])
			2'd0: g = r[3:0];
			2'd1: g = 4'((r[3:0] << 2) + r[3:0] + 4'd1);
			2'd2: g = 4'((r[3:0] << 1) + r[3:0] + 4'd5);
			2'd3: g = 4'((r[3:0] << 3) - r[3:0]);
			default: g = 4'd0;
		endcase
		return g;
	endfunction

endpackage

// ===== design/md5_message_digest.sv =====
// MD5 engine top level: 16-word message memory, padding sequencer, one-step-per-cycle
// compression and digest output register. Depends on md5_pkg.
//
// Throughput: one word per cycle is taken while the buffer fills; each full 16-word
// block then holds the input through the load, the 64 steps and the chain add.
// Padding after the last word writes one memory entry a cycle; the message tail is
// compressed in one or two blocks before the digest.
// Reset clears all control state, loads the initial vector and drops the output word.
module md5_message_digest
	import md5_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        word_valid,
	output logic        word_stall,
	input  md5_word_t   word,
	output logic        digest_valid,
	input  logic        digest_stall,
	output md5_digest_t digest
);

	// Sequencer states.
	localparam logic [2:0] S_IDLE = 3'd0; // accept message words
	localparam logic [2:0] S_PAD  = 3'd1; // write 0x80, zero fill, length
	localparam logic [2:0] S_LOAD = 3'd2; // copy chain, prime first memory read
	localparam logic [2:0] S_RUN  = 3'd3; // one MD5 step per cycle
	localparam logic [2:0] S_ADD  = 3'd4; // fold step registers into the chain
	localparam logic [2:0] S_EMIT = 3'd5; // hand digest to the output register

	logic [2:0]  state_q;
	logic [3:0]  fill_q;      // next free entry of the message memory
	logic [5:0]  round_q;
	logic [63:0] bitlen_q;
	logic        padding_q;   // last word seen, tail still being built
	logic        pend80_q;    // last word was full: 0x80 goes in the next entry
	logic        len_ok_q;    // current block has room for the length
	logic        final_q;     // block in flight carries the length
	logic [31:0] ca_q, cb_q, cc_q, cd_q;
	logic [31:0] wa_q, wb_q, wc_q, wd_q;
	logic        out_valid_q;
	md5_digest_t out_q;

	// Message memory: one write port at the fill index, one registered read port.
	logic [31:0] msg_mem [16];
	logic [31:0] mem_rd_q;
	logic        mem_we;
	logic [31:0] mem_wdata;
	logic [3:0]  rd_addr;

	logic        word_take;
	logic        out_free;
	logic        out_load;
	logic [31:0] last_data;
	logic [63:0] bitlen_add;
	logic        len_ok_next;
	logic        pad_final;

	logic [31:0] f_val;
	logic [31:0] step_sum;
	logic [63:0] step_rot_w;
	logic [31:0] step_b;

	assign word_take = word_valid && !word_stall;
	assign word_stall = (state_q != S_IDLE);
	assign out_free = !out_valid_q || !digest_stall;
	assign out_load = (state_q == S_EMIT) && out_free;

	// Mask the bytes past the count and append the 0x80 marker in the same entry.
	always_comb begin
		unique case (word.byte_count[1:0])
			2'd0: last_data = PAD_BYTE;
			2'd1: last_data = {16'h0, 8'h80, word.message_word[7:0]};
			2'd2: last_data = {8'h0, 8'h80, word.message_word[15:0]};
			2'd3: last_data = {8'h80, word.message_word[23:0]};
			default: last_data = PAD_BYTE;
		endcase
	end

	// A count of four or more on the last word counts as four; other words are full.
	assign bitlen_add = (!word.last_word || word.byte_count[2]) ? 64'd32
		: {59'd0, word.byte_count[1:0], 3'b000};

	// After the marker is written, the length fits if the marker sat at entry 13 or
	// lower, or if the marker closed the block and a fresh one follows.
	assign len_ok_next = (fill_q == 4'd15) || (fill_q <= 4'd13);

	// The high length word at entry 15 closes the message.
	assign pad_final = !pend80_q && len_ok_q && (fill_q == 4'd15);

	always_comb begin
		mem_we = 1'b0;
		mem_wdata = word.message_word;
		priority if (state_q == S_IDLE) begin
			mem_we = word_take;
			if (word.last_word && !word.byte_count[2]) begin
				mem_wdata = last_data;
			end
		end else if (state_q == S_PAD) begin
			mem_we = 1'b1;
			priority if (pend80_q) begin
				mem_wdata = PAD_BYTE;
			end else if (len_ok_q && fill_q == 4'd14) begin
				mem_wdata = bitlen_q[31:0];
			end else if (len_ok_q && fill_q == 4'd15) begin
				mem_wdata = bitlen_q[63:32];
			end else begin
				mem_wdata = 32'h0;
			end
		end
	end

	// Fetch one step ahead so the word is in mem_rd_q when its step runs.
	assign rd_addr = (state_q == S_LOAD) ? step_index(6'd0) : step_index(6'(round_q + 6'd1));

	always_ff @(posedge clk) begin
		if (mem_we) begin
			msg_mem[fill_q] <= mem_wdata;
		end
		mem_rd_q <= msg_mem[rd_addr];
	end

	// One MD5 step.
	always_comb begin
		unique case (round_q[5:4])
			2'd0: f_val = (wb_q & wc_q) | (~wb_q & wd_q);
			2'd1: f_val = (wd_q & wb_q) | (~wd_q & wc_q);
			2'd2: f_val = wb_q ^ wc_q ^ wd_q;
			2'd3: f_val = wc_q ^ (wb_q | ~wd_q);
			default: f_val = 32'h0;
		endcase
	end

	assign step_sum = f_val + wa_q + step_const(round_q) + mem_rd_q;
	assign step_rot_w = {step_sum, step_sum} << step_shift(round_q);
	assign step_b = wb_q + step_rot_w[63:32];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			fill_q <= 4'd0;
			round_q <= 6'd0;
			bitlen_q <= 64'd0;
			padding_q <= 1'b0;
			pend80_q <= 1'b0;
			len_ok_q <= 1'b0;
			final_q <= 1'b0;
			ca_q <= IV_A;
			cb_q <= IV_B;
			cc_q <= IV_C;
			cd_q <= IV_D;
			wa_q <= 32'h0;
			wb_q <= 32'h0;
			wc_q <= 32'h0;
			wd_q <= 32'h0;
			out_valid_q <= 1'b0;
		end else begin
			// Raise the output word when loaded, drop it once taken.
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (out_free) begin
				out_valid_q <= 1'b0;
			end
			if (mem_we) begin
				fill_q <= fill_q + 4'd1;
			end
			unique case (state_q)
				S_IDLE: begin
					if (word_take) begin
						bitlen_q <= bitlen_q + bitlen_add;
						if (word.last_word) begin
							padding_q <= 1'b1;
							pend80_q <= word.byte_count[2];
							len_ok_q <= len_ok_next;
						end
						if (fill_q == 4'd15) begin
							state_q <= S_LOAD;
						end else if (word.last_word) begin
							state_q <= S_PAD;
						end
					end
				end
				S_PAD: begin
					// Drop the pending marker once written and note whether the length fits.
					if (pend80_q) begin
						pend80_q <= 1'b0;
						len_ok_q <= len_ok_next;
					end else if (fill_q == 4'd15) begin
						len_ok_q <= 1'b1;
					end
					if (pad_final) begin
						final_q <= 1'b1;
					end
					if (fill_q == 4'd15) begin
						state_q <= S_LOAD;
					end
				end
				S_LOAD: begin
					wa_q <= ca_q;
					wb_q <= cb_q;
					wc_q <= cc_q;
					wd_q <= cd_q;
					round_q <= 6'd0;
					state_q <= S_RUN;
				end
				S_RUN: begin
					wa_q <= wd_q;
					wb_q <= step_b;
					wc_q <= wb_q;
					wd_q <= wc_q;
					round_q <= round_q + 6'd1;
					if (round_q == 6'd63) begin
						state_q <= S_ADD;
					end
				end
				S_ADD: begin
					ca_q <= ca_q + wa_q;
					cb_q <= cb_q + wb_q;
					cc_q <= cc_q + wc_q;
					cd_q <= cd_q + wd_q;
					priority if (final_q) begin
						state_q <= S_EMIT;
					end else if (padding_q) begin
						state_q <= S_PAD;
					end else begin
						state_q <= S_IDLE;
					end
				end
				S_EMIT: begin
					// Hold until the output register is free, then restart from the IV.
					if (out_free) begin
						ca_q <= IV_A;
						cb_q <= IV_B;
						cc_q <= IV_C;
						cd_q <= IV_D;
						bitlen_q <= 64'd0;
						padding_q <= 1'b0;
						pend80_q <= 1'b0;
						len_ok_q <= 1'b0;
						final_q <= 1'b0;
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			out_q.digest_a <= ca_q;
			out_q.digest_b <= cb_q;
			out_q.digest_c <= cc_q;
			out_q.digest_d <= cd_q;
		end
	end

	assign digest_valid = out_valid_q;
	assign digest = out_q;

	// The memory is never written while the steps read it.
	a_no_write_in_run: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_RUN || state_q == S_LOAD) |-> !mem_we)
		else $error("message memory written during compression");

	// Writing the last entry of a block always starts a compression.
	a_full_starts_load: assert property (@(posedge clk) disable iff (!arst_n)
		(mem_we && fill_q == 4'd15) |=> (state_q == S_LOAD))
		else $error("full block did not start compression");

	// Step 63 is followed by the chain add.
	a_run_ends: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_RUN && round_q == 6'd63) |=> (state_q == S_ADD))
		else $error("step counter did not end at the chain add");

	// A digest leaves with the buffer empty and the length cleared.
	a_emit_clean: assert property (@(posedge clk) disable iff (!arst_n)
		out_load |=> (fill_q == 4'd0 && bitlen_q == 64'd0 && digest_valid))
		else $error("digest emitted with stale message state");

	// A waiting digest is never overwritten.
	a_out_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		(digest_valid && digest_stall) |-> !out_load)
		else $error("stalled digest overwritten");

endmodule
